@@ rtl/hvd_pkg.sv @@
// Shared types, constants and arithmetic helpers for the haversine distance pipeline.
// No dependencies; every other file of the block imports this package.
package hvd_pkg;

    // Angle and CORDIC configuration
    localparam int ANGLE_FRAC_BITS = 20;
    localparam int CORDIC_STEPS    = 24;
    localparam int G               = ANGLE_FRAC_BITS + 1;   // half-difference fraction bits
    localparam int Q_FRAC          = 30;                    // fraction bits of unit values

    // Square root: one result bit per step
    localparam int SQRT_STEPS = Q_FRAC + 1;
    localparam int SQRT_W     = 2 * Q_FRAC + 2;

    // Payload types
    typedef logic signed [27:0] t_lat;
    typedef logic signed [28:0] t_lon;
    typedef logic        [32:0] t_dist;
    typedef logic        [22:0] t_radius;

    // Internal types
    typedef logic signed [31:0]       t_deg;    // degrees, G fraction bits
    typedef logic signed [31:0]       t_q30;    // sine, cosine, products
    typedef logic signed [32:0]       t_ang;    // CORDIC angle accumulator
    typedef logic signed [33:0]       t_cx;     // CORDIC x and y
    typedef logic        [Q_FRAC:0]   t_root;   // unsigned value in [0, 2^Q_FRAC]

    localparam t_deg DEG_FULL    = t_deg'(64'd360 << G);
    localparam t_deg DEG_HALF    = t_deg'(64'd180 << G);
    localparam t_deg DEG_QUARTER = t_deg'(64'd90 << G);
    localparam int   RED_W       = $clog2(int'(DEG_QUARTER) + 1);

    localparam logic [26:0] DEG_TO_RAD = 27'd74961321;     // pi/180, 32 fraction bits
    localparam int          PROD_W     = RED_W + 27;

    localparam t_cx   INV_GAIN = t_cx'(652032874);
    localparam t_q30  ONE_Q30  = t_q30'(64'd1 << Q_FRAC);
    localparam t_root ONE_ROOT = t_root'(64'd1 << Q_FRAC);
    localparam t_ang  HALF_PI  = t_ang'(1686629713);

    localparam t_radius RADIUS_RESET = 23'd6371000;

    // atan(2^-i), Q30, rounded to nearest
    function automatic t_ang atan_q30(input int i);
        t_ang v;
        case (i)
            0:       v = t_ang'(843314857);
            1:       v = t_ang'(497837829);
            2:       v = t_ang'(263043837);
            3:       v = t_ang'(133525159);
            4:       v = t_ang'(67021687);
            5:       v = t_ang'(33543516);
            6:       v = t_ang'(16775851);
            7:       v = t_ang'(8388437);
            8:       v = t_ang'(4194283);
            9:       v = t_ang'(2097149);
            default: begin
                if (i <= Q_FRAC) begin
                    v = t_ang'(64'd1 << (Q_FRAC - i));
                end else begin
                    v = '0;
                end
            end
        endcase
        return v;
    endfunction

    // Product of two Q30 values, rounded, floor shift
    function automatic t_q30 mul_q30(input t_q30 a, input t_q30 b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + (64'sd1 <<< (Q_FRAC - 1));
        return p[Q_FRAC+31:Q_FRAC];
    endfunction

endpackage

@@ rtl/hvd_in_if.sv @@
// Request channel of the haversine distance block: two points per request.
// Depends on hvd_pkg for the coordinate types.
interface hvd_in_if;
    import hvd_pkg::*;

    logic valid;
    logic ready;
    t_lat own_latitude;
    t_lon own_longitude;
    t_lat other_latitude;
    t_lon other_longitude;

    modport source (
        output valid, own_latitude, own_longitude, other_latitude, other_longitude,
        input  ready
    );
    modport sink (
        input  valid, own_latitude, own_longitude, other_latitude, other_longitude,
        output ready
    );
endinterface

@@ rtl/hvd_out_if.sv @@
// Result channel of the haversine distance block: one distance per request.
// Depends on hvd_pkg for the distance type.
interface hvd_out_if;
    import hvd_pkg::*;

    logic  valid;
    logic  ready;
    t_dist distance;

    modport source (output valid, distance, input ready);
    modport sink   (input valid, distance, output ready);
endinterface

@@ rtl/hvd_sin_pipe.sv @@
// Pipelined sine of an angle in degrees: quadrant reduction, conversion to
// radians and one CORDIC rotation step per stage. Depends on hvd_pkg.
module hvd_sin_pipe (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  hvd_pkg::t_deg i_deg,
    output logic          o_valid,
    output hvd_pkg::t_q30 o_sin
);
    import hvd_pkg::*;

    // reduce, mirror, multiply, rad, CORDIC steps, clamp
    localparam int LAT = CORDIC_STEPS + 5;

    logic              r_vld [0:LAT-1];
    logic              r_neg [0:LAT-2];
    t_deg              n_r1;
    logic              n_neg;
    t_deg              r_r1;
    logic [RED_W-1:0]  r_r2;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W:0]   rnd;
    t_cx               r_x [0:CORDIC_STEPS];
    t_cx               r_y [0:CORDIC_STEPS];
    t_ang              r_z [0:CORDIC_STEPS];
    t_q30              n_sin;
    t_q30              r_sin;

    // valid and sign travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= n_neg;
            for (int k = 1; k < LAT - 1; k++) r_neg[k] <= r_neg[k-1];
        end
    end

    // half-turn reduction: the input lies within one full turn either way
    always_comb begin
        if (i_deg >= DEG_HALF) begin
            n_r1  = i_deg - DEG_HALF;
            n_neg = 1'b1;
        end else if (i_deg >= 0) begin
            n_r1  = i_deg;
            n_neg = 1'b0;
        end else if (i_deg >= -DEG_HALF) begin
            n_r1  = i_deg + DEG_HALF;
            n_neg = 1'b1;
        end else begin
            n_r1  = i_deg + DEG_FULL;
            n_neg = 1'b0;
        end
    end

    assign rnd = {1'b0, r_prod} + (PROD_W+1)'(64'd1 << (G + 1));

    // mirror into the first quadrant, convert to radians
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r1   <= n_r1;
            r_r2   <= (r_r1 > DEG_QUARTER) ? RED_W'(DEG_HALF - r_r1) : RED_W'(r_r1);
            r_prod <= PROD_W'(r_r2) * PROD_W'(DEG_TO_RAD);
            r_x[0] <= INV_GAIN;
            r_y[0] <= '0;
            r_z[0] <= t_ang'(rnd >> (G + 2));
        end
    end

    // rotation steps
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        t_cx dx, dy;
        assign dx = r_y[k] >>> k;
        assign dy = r_x[k] >>> k;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[k] >= 0) begin
                    r_x[k+1] <= r_x[k] - dx;
                    r_y[k+1] <= r_y[k] + dy;
                    r_z[k+1] <= r_z[k] - atan_q30(k);
                end else begin
                    r_x[k+1] <= r_x[k] + dx;
                    r_y[k+1] <= r_y[k] - dy;
                    r_z[k+1] <= r_z[k] + atan_q30(k);
                end
            end
        end
    end

    // clamp to the unit range, apply the half-turn sign
    always_comb begin
        if (r_y[CORDIC_STEPS] > t_cx'(ONE_Q30)) begin
            n_sin = ONE_Q30;
        end else if (r_y[CORDIC_STEPS] < -t_cx'(ONE_Q30)) begin
            n_sin = -ONE_Q30;
        end else begin
            n_sin = t_q30'(r_y[CORDIC_STEPS]);
        end
        if (r_neg[LAT-2]) begin
            n_sin = -n_sin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= n_sin;
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_sin   = r_sin;
endmodule

@@ rtl/hvd_isqrt_pipe.sv @@
// Pipelined exact floor square root of a Q30 value, one result bit per stage.
// Depends on hvd_pkg.
module hvd_isqrt_pipe (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  hvd_pkg::t_root i_value,
    output logic           o_valid,
    output hvd_pkg::t_root o_root
);
    import hvd_pkg::*;

    logic              r_vld [0:SQRT_STEPS-1];
    logic [SQRT_W-1:0] r_rem [1:SQRT_STEPS];
    logic [SQRT_W-1:0] r_res [1:SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQRT_STEPS; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < SQRT_STEPS; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // restoring square root, trial bit 4^(Q_FRAC-k)
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * Q_FRAC - 2 * k);
        logic [SQRT_W-1:0] cur_rem, cur_res, trial;
        if (k == 0) begin : g_first
            assign cur_rem = SQRT_W'(i_value) << Q_FRAC;
            assign cur_res = '0;
        end else begin : g_next
            assign cur_rem = r_rem[k];
            assign cur_res = r_res[k];
        end
        assign trial = cur_res + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (cur_rem >= trial) begin
                    r_rem[k+1] <= cur_rem - trial;
                    r_res[k+1] <= (cur_res >> 1) + BIT;
                end else begin
                    r_rem[k+1] <= cur_rem;
                    r_res[k+1] <= cur_res >> 1;
                end
            end
        end
    end

    assign o_valid = r_vld[SQRT_STEPS-1];
    assign o_root  = t_root'(r_res[SQRT_STEPS]);
endmodule

@@ rtl/hvd_asin_pipe.sv @@
// Pipelined arcsine by CORDIC vectoring on (sqrt(1-a), sqrt(a)), one step per
// stage, then a clamp to [0, pi/2]. Depends on hvd_pkg.
module hvd_asin_pipe (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  hvd_pkg::t_root i_x,
    input  hvd_pkg::t_root i_y,
    output logic           o_valid,
    output hvd_pkg::t_root o_angle
);
    import hvd_pkg::*;

    localparam int LAT = CORDIC_STEPS + 1;

    logic  r_vld [0:LAT-1];
    t_cx   r_x [1:CORDIC_STEPS];
    t_cx   r_y [1:CORDIC_STEPS];
    t_ang  r_z [1:CORDIC_STEPS];
    t_root r_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // vectoring steps drive y towards zero
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        t_cx  cur_x, cur_y, dx, dy;
        t_ang cur_z;
        if (k == 0) begin : g_first
            assign cur_x = t_cx'(i_x);
            assign cur_y = t_cx'(i_y);
            assign cur_z = '0;
        end else begin : g_next
            assign cur_x = r_x[k];
            assign cur_y = r_y[k];
            assign cur_z = r_z[k];
        end
        assign dx = cur_y >>> k;
        assign dy = cur_x >>> k;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (cur_y >= 0) begin
                    r_x[k+1] <= cur_x + dx;
                    r_y[k+1] <= cur_y - dy;
                    r_z[k+1] <= cur_z + atan_q30(k);
                end else begin
                    r_x[k+1] <= cur_x - dx;
                    r_y[k+1] <= cur_y + dy;
                    r_z[k+1] <= cur_z - atan_q30(k);
                end
            end
        end
    end

    // clamp the angle to [0, pi/2]
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_z[CORDIC_STEPS] < 0) begin
                r_angle <= '0;
            end else if (r_z[CORDIC_STEPS] > HALF_PI) begin
                r_angle <= t_root'(HALF_PI);
            end else begin
                r_angle <= t_root'(r_z[CORDIC_STEPS]);
            end
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_angle = r_angle;
endmodule

@@ rtl/haversine_distance.sv @@
// Haversine great-circle distance between two points, fully pipelined.
// Depends on hvd_pkg, hvd_in_if, hvd_out_if, hvd_sin_pipe, hvd_isqrt_pipe, hvd_asin_pipe.
//
// Usage:
//   i_req carries one request: two points as latitude and longitude in signed
//   degrees with 20 fraction bits. o_res returns one distance per request, in
//   1/256 of the radius unit, in request order. A request is taken at a clock
//   edge with valid and ready both high; likewise a result.
//   i_cfg_we/i_cfg_wdata set the sphere radius; write it only while no
//   request is in flight. Reset sets it to 6371000 (Earth in metres).
//   Throughput: one request per cycle while o_res does not stall. The
//   input register, the four parallel sine pipes (29 stages each), three
//   multiply stages, the 31-stage square root, the 25-stage arcsine and the
//   final multiply and output register make 91 stages, the first loaded at
//   the request edge. When the receiver stalls the whole pipeline holds;
//   i_req.ready follows o_res.ready while a result waits, so nothing is lost
//   or repeated.
//   Synchronous reset empties the pipeline; payload registers are not cleared.
module haversine_distance (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hvd_in_if.sink           i_req,
    hvd_out_if.source        o_res,
    input  logic             i_cfg_we,
    input  hvd_pkg::t_radius i_cfg_wdata
);
    import hvd_pkg::*;

    logic    en;
    t_radius r_radius;

    logic    r_v1;
    t_deg    r_dlat, r_dlon, r_c1arg, r_c2arg;

    logic    v_sin;
    t_q30    sa, so, c1, c2;

    logic    r_vm1, r_vm2, r_vm3;
    t_q30    r_sa2, r_so2, r_cp, r_t, r_sa2b;
    t_ang    sum_a;
    t_root   r_a, r_b;

    logic    v_sqrt;
    t_root   root_y, root_x;

    logic    v_asin;
    t_root   angle;

    logic        r_vp;
    logic [53:0] r_prod;
    logic [53:0] rnd;
    logic        r_out_vld;
    t_dist       r_dist;

    // global advance: hold everything while a result waits unaccepted
    assign en          = !r_out_vld || o_res.ready;
    assign i_req.ready = en;

    // radius register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    // valid bits of the top-level stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_vm1     <= 1'b0;
            r_vm2     <= 1'b0;
            r_vm3     <= 1'b0;
            r_vp      <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_v1      <= i_req.valid;
            r_vm1     <= v_sin;
            r_vm2     <= r_vm1;
            r_vm3     <= r_vm2;
            r_vp      <= v_asin;
            r_out_vld <= r_vp;
        end
    end

    // half differences and cosine arguments (cos x = sin(x + 90))
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dlat  <= t_deg'(i_req.other_latitude) - t_deg'(i_req.own_latitude);
            r_dlon  <= t_deg'(i_req.other_longitude) - t_deg'(i_req.own_longitude);
            r_c1arg <= (t_deg'(i_req.own_latitude) <<< 1) + DEG_QUARTER;
            r_c2arg <= (t_deg'(i_req.other_latitude) <<< 1) + DEG_QUARTER;
        end
    end

    hvd_sin_pipe u_sin_lat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v1),
        .i_deg(r_dlat), .o_valid(v_sin), .o_sin(sa)
    );
    hvd_sin_pipe u_sin_lon (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v1),
        .i_deg(r_dlon), .o_valid(), .o_sin(so)
    );
    hvd_sin_pipe u_cos_own (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v1),
        .i_deg(r_c1arg), .o_valid(), .o_sin(c1)
    );
    hvd_sin_pipe u_cos_other (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v1),
        .i_deg(r_c2arg), .o_valid(), .o_sin(c2)
    );

    // haversine term: squares and cosine product, then the cross term, then a and 1-a clamped to [0, 1]
    assign sum_a = t_ang'(r_sa2b) + t_ang'(r_t);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa2  <= mul_q30(sa, sa);
            r_so2  <= mul_q30(so, so);
            r_cp   <= mul_q30(c1, c2);
            r_t    <= mul_q30(r_cp, r_so2);
            r_sa2b <= r_sa2;
            if (sum_a < 0) begin
                r_a <= '0;
                r_b <= ONE_ROOT;
            end else if (sum_a > t_ang'(ONE_Q30)) begin
                r_a <= ONE_ROOT;
                r_b <= '0;
            end else begin
                r_a <= t_root'(sum_a);
                r_b <= ONE_ROOT - t_root'(sum_a);
            end
        end
    end

    hvd_isqrt_pipe u_sqrt_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_vm3),
        .i_value(r_a), .o_valid(v_sqrt), .o_root(root_y)
    );
    hvd_isqrt_pipe u_sqrt_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_vm3),
        .i_value(r_b), .o_valid(), .o_root(root_x)
    );

    hvd_asin_pipe u_asin (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v_sqrt),
        .i_x(root_x), .i_y(root_y), .o_valid(v_asin), .o_angle(angle)
    );

    // scale by the radius and round to 1/256 unit
    assign rnd = r_prod + (54'd1 << 20);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= 54'(r_radius) * 54'(angle);
            r_dist <= rnd[53:21];
        end
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.distance = r_dist;
endmodule
